FILE: rtl/core/dtfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared constants, types and helpers for the decimal text to fixed point block.
// ----------------------------------------------------------------------------
package dtfp_pkg;

  // Number format
  localparam int FRAC_DIGITS = 5;
  localparam int FRAC_BITS   = 16;
  localparam int INT_BITS    = 31;
  localparam int VALUE_W     = 48;
  localparam int STATUS_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;

  // Stream data widths, padded to whole bytes
  localparam int S_TDATA_W = ((CHAR_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((VALUE_W + STATUS_W + 7) / 8) * 8;

  // Power of ten, elaboration only
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // Fraction digits are normalized to FRAC_DIGITS digits before conversion
  localparam longint unsigned FRAC_DEN  = pow10(FRAC_DIGITS);
  localparam longint unsigned FRAC_HALF = FRAC_DEN / 2;
  localparam int FRAC_W = $clog2(FRAC_DEN);
  localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);

  // Reciprocal divide: X = frac * 2^FRAC_BITS + half, q = X / FRAC_DEN
  localparam int X_W   = FRAC_W + FRAC_BITS;
  localparam int RCP_W = FRAC_BITS + 1;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam longint unsigned RCP = (64'd1 << X_W) / FRAC_DEN;

  // Magnitude and its limit
  localparam int MAG_W = INT_BITS + FRAC_BITS + 1;
  localparam longint unsigned FMT_LIM = (64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1;
  localparam longint unsigned VAL_LIM = (64'd1 << (VALUE_W - 1)) - 64'd1;
  localparam longint unsigned MAG_LIM = (FMT_LIM < VAL_LIM) ? FMT_LIM : VAL_LIM;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_BAD_CHAR     = 2'd1,
    ST_SECOND_POINT = 2'd2,
    ST_OVERFLOW     = 2'd3
  } status_t;

  // Parser state captured on the terminator
  typedef struct packed {
    status_t             err;
    logic [INT_BITS-1:0] int_part;
    logic [FRAC_W-1:0]   frac_part;
    logic [FCNT_W-1:0]   frac_cnt;
    logic                neg;
  } snap_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } result_t;

  // Scale that brings n kept digits up to FRAC_DIGITS digits
  function automatic logic [FRAC_W-1:0] frac_scale(input logic [FCNT_W-1:0] n);
    logic [FRAC_W-1:0] s;
    s = '0;
    for (int i = 0; i <= FRAC_DIGITS; i++) begin
      if (n == FCNT_W'(i)) s = FRAC_W'(pow10(FRAC_DIGITS - i));
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/dtfp_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfp_convert
// Pipeline that turns a captured parser state into the signed fixed-point
// value and status: digit normalize, reciprocal divide, round, saturate.
// ----------------------------------------------------------------------------
module dtfp_convert import dtfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  snap_t   in_snap,
  output logic    out_valid,
  output result_t out_res
);

  logic v1, v2, v3, v4, v5, v6;
  snap_t sn1, sn2, sn3, sn4, sn5;
  status_t err6;
  logic neg6;
  logic [FRAC_W-1:0] f5;
  logic [X_W-1:0] x2, x3, x4;
  logic [X_W+RCP_W-1:0] prod3;
  logic [Q_W-1:0] q3, q4, q5;
  logic [X_W-1:0] qd4;
  logic [X_W-1:0] rem5;
  logic [MAG_W-1:0] mag_sum, mag6;
  logic [VALUE_W-1:0] mag_v;

  // Stage 1: normalize kept digits to FRAC_DIGITS digits
  assign f5 = FRAC_W'(sn1.frac_part * frac_scale(sn1.frac_cnt));

  // Stage 3: quotient estimate, low by at most one
  assign prod3 = x3 * (X_W+RCP_W)'(RCP);
  assign q3    = prod3[X_W +: Q_W];

  // Stage 5: remainder check corrects the estimate
  assign rem5 = x4 - qd4;

  // Stage 6 input: integer and rounded fraction
  assign mag_sum = (MAG_W'(sn5.int_part) << FRAC_BITS) + MAG_W'(q5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      sn1 <= in_snap;

      sn2 <= sn1;
      x2  <= (X_W'(f5) << FRAC_BITS) + X_W'(FRAC_HALF);

      sn3 <= sn2;
      x3  <= x2;

      sn4 <= sn3;
      x4  <= x3;
      q4  <= q3;
      qd4 <= X_W'(q3 * X_W'(FRAC_DEN));

      sn5 <= sn4;
      q5  <= q4 + Q_W'(rem5 >= X_W'(FRAC_DEN));

      neg6 <= sn5.neg;
      if (mag_sum > MAG_W'(MAG_LIM)) begin
        mag6 <= MAG_W'(MAG_LIM);
        err6 <= (sn5.err == ST_OK) ? ST_OVERFLOW : sn5.err;
      end else begin
        mag6 <= mag_sum;
        err6 <= sn5.err;
      end
    end
  end

  // Sign and error masking
  assign mag_v     = VALUE_W'(mag6);
  assign out_valid = v6;
  always_comb begin
    out_res.status = err6;
    if (err6 == ST_BAD_CHAR || err6 == ST_SECOND_POINT) out_res.value = '0;
    else if (neg6) out_res.value = -mag_v;
    else out_res.value = mag_v;
  end

endmodule

FILE: rtl/core/decimal_text_to_fixed_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// ASCII decimal number to signed fixed-point (INT_BITS.FRAC_BITS) converter.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one character per request, char_code in s_tdata[7:0],
//   is_terminator in s_tuser. Characters are taken one per cycle while
//   s_tready is high; each one updates the parser state in a single
//   multiply-by-ten accumulate. A request with s_tuser set ends the string:
//   the parser state is cleared, so the next string may start in the very
//   next cycle, and handed to a six-stage conversion pipeline whose result
//   passes through the output register. Only terminators produce a result.
//   Master channel: one result per terminator, value and status in m_tdata.
//   One request per cycle unless stalled, set by the accumulate loop.
//   Stall: a skid register behind the output register takes one extra result;
//   once it is occupied s_tready drops and the pipeline holds until the
//   receiver takes the waiting result.
//   Reset (rst, synchronous): parser back to the start of a string, pipeline
//   and output emptied.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point import dtfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_code
  input  logic                 s_tuser,   // [0] is_terminator
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // [47:0] value, [49:48] status, rest zero
);

  // Parser state
  logic [INT_BITS-1:0] int_acc, int_acc_next;
  logic [FRAC_W-1:0]   frac_acc, frac_acc_next;
  logic [FCNT_W-1:0]   frac_cnt, frac_cnt_next;
  logic                point_seen, point_seen_next;
  logic                neg, neg_next;
  logic                first, first_next;
  status_t             err, err_next;

  logic [CHAR_W-1:0]     c;
  logic                  take;
  logic                  is_digit;
  logic [DIGIT_W-1:0]    d;
  logic [INT_BITS+3:0]   int_grow;
  logic [FRAC_W+3:0]     frac_grow;
  logic                  en;
  snap_t                 snap;
  logic                  res_valid;
  result_t               res;
  result_t               out_res, skid_res;
  logic                  skid_valid;

  assign c        = s_tdata[CHAR_W-1:0];
  assign en       = !skid_valid;
  assign s_tready = en;
  assign take     = s_tvalid && s_tready;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign d        = DIGIT_W'(c - CH_ZERO);

  // Multiply-by-ten accumulate
  assign int_grow  = ((INT_BITS+4)'(int_acc) << 3) + ((INT_BITS+4)'(int_acc) << 1)
                   + (INT_BITS+4)'(d);
  assign frac_grow = ((FRAC_W+4)'(frac_acc) << 3) + ((FRAC_W+4)'(frac_acc) << 1)
                   + (FRAC_W+4)'(d);

  // Character handling
  always_comb begin
    int_acc_next    = int_acc;
    frac_acc_next   = frac_acc;
    frac_cnt_next   = frac_cnt;
    point_seen_next = point_seen;
    neg_next        = neg;
    first_next      = first;
    err_next        = err;
    if (take && s_tuser) begin
      int_acc_next    = '0;
      frac_acc_next   = '0;
      frac_cnt_next   = '0;
      point_seen_next = 1'b0;
      neg_next        = 1'b0;
      first_next      = 1'b1;
      err_next        = ST_OK;
    end else if (take) begin
      first_next = 1'b0;
      if (err != ST_BAD_CHAR && err != ST_SECOND_POINT) begin
        if (is_digit) begin
          if (point_seen) begin
            if (frac_cnt < FCNT_W'(FRAC_DIGITS)) begin
              frac_acc_next = frac_grow[FRAC_W-1:0];
              frac_cnt_next = frac_cnt + 1'b1;
            end
          end else if (int_grow > (INT_BITS+4)'({INT_BITS{1'b1}})) begin
            int_acc_next = {INT_BITS{1'b1}};
            if (err == ST_OK) err_next = ST_OVERFLOW;
          end else begin
            int_acc_next = int_grow[INT_BITS-1:0];
          end
        end else if (c == CH_POINT) begin
          if (point_seen) begin
            if (err == ST_OK) err_next = ST_SECOND_POINT;
          end else begin
            point_seen_next = 1'b1;
          end
        end else if (c == CH_MINUS && first) begin
          neg_next = 1'b1;
        end else if (err == ST_OK) begin
          err_next = ST_BAD_CHAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_cnt   <= '0;
      point_seen <= 1'b0;
      neg        <= 1'b0;
      first      <= 1'b1;
      err        <= ST_OK;
    end else begin
      int_acc    <= int_acc_next;
      frac_acc   <= frac_acc_next;
      frac_cnt   <= frac_cnt_next;
      point_seen <= point_seen_next;
      neg        <= neg_next;
      first      <= first_next;
      err        <= err_next;
    end
  end

  // State handed over on the terminator
  assign snap.err       = err;
  assign snap.int_part  = int_acc;
  assign snap.frac_part = frac_acc;
  assign snap.frac_cnt  = frac_cnt;
  assign snap.neg       = neg;

  dtfp_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (take && s_tuser),
    .in_snap   (snap),
    .out_valid (res_valid),
    .out_res   (res)
  );

  // Output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_res  <= res;
        m_tvalid <= en && res_valid;
      end
    end else if (en && res_valid) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign m_tdata = M_TDATA_W'({out_res.status, out_res.value});

endmodule
